// ===== design/record_deque_with_search_assert.svh =====
// Assertion macros shared by the record deque design.
`ifndef RECORD_DEQUE_WITH_SEARCH_ASSERT_SVH
`define RECORD_DEQUE_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication under synchronous reset.
`define RDWS_ASSERT_NOW(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("record deque check failed");

// Next-cycle implication under synchronous reset.
`define RDWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("record deque check failed");

`endif

// ===== design/rdws_pkg.sv =====
// Types and constants of the record deque with search.
`timescale 1ns / 1ps
package rdws_pkg;

   localparam int OPCODE_W = 3;
   localparam int ID_W     = 24;
   localparam int GROUP_W  = 4;
   localparam int USAGE_W  = 16;
   localparam int RATE_W   = 16;
   localparam int BILL_W   = 32;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 2;

   localparam logic [RATE_W-1:0] RATE_RESET = 16'd500;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_SEARCH     = 3'd6,
      OP_DUMP       = 3'd7
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_DECODE = 3'd1,
      S_FETCH  = 3'd2,
      S_LOAD   = 3'd3,
      S_MUL    = 3'd4,
      S_EMIT   = 3'd5
   } state_type;

   typedef enum logic [1:0] {
      STG_HOLD = 2'd0,
      STG_CMD  = 2'd1,
      STG_RAM  = 2'd2,
      STG_ERR  = 2'd3
   } stage_src_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [GROUP_W-1:0] group;
      logic [USAGE_W-1:0] usage;
   } record_type;

   typedef struct packed {
      logic          take_cmd;
      logic          push;
      logic          pop;
      logic          walk_inc;
      stage_src_type stg_src;
      status_type    stg_status;
      logic          stg_last;
      logic          ld_prod;
      logic          ld_out;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       full;
      logic       empty;
      logic       match;
      logic       walk_end;
      logic       out_free;
      logic       stg_last;
   } dp_stat_type;

endpackage

// ===== design/rdws_req_if.sv =====
// Request channel interface: command items into the deque.
`timescale 1ns / 1ps
interface rdws_req_if;
   import rdws_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [ID_W-1:0]     customer_id;
   logic [GROUP_W-1:0]  tariff_group;
   logic [USAGE_W-1:0]  usage_amount;
   logic                dump_reverse;

   modport source (
      output valid, opcode, customer_id, tariff_group, usage_amount, dump_reverse,
      input  ready
   );

   modport sink (
      input  valid, opcode, customer_id, tariff_group, usage_amount, dump_reverse,
      output ready
   );
endinterface

// ===== design/rdws_rsp_if.sv =====
// Response channel interface: result items out of the deque.
`timescale 1ns / 1ps
interface rdws_rsp_if;
   import rdws_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    position;
   logic [ID_W-1:0]     record_id;
   logic [GROUP_W-1:0]  record_group;
   logic [USAGE_W-1:0]  record_usage;
   logic [BILL_W-1:0]   bill;
   logic                last;

   modport source (
      output valid, status, position, record_id, record_group, record_usage, bill, last,
      input  ready
   );

   modport sink (
      input  valid, status, position, record_id, record_group, record_usage, bill, last,
      output ready
   );
endinterface

// ===== design/rdws_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module rdws_ram #(
   parameter int WIDTH = 44,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/rdws_ctrl.sv =====
// Controller state machine of the record deque.
`timescale 1ns / 1ps
module rdws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rdws_pkg::dp_stat_type dp_stat,
   output rdws_pkg::dp_cmd_type  dp_cmd
);
   import rdws_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.take_cmd = 1'b1;
               state_in        = S_DECODE;
            end
         end
         S_DECODE: begin
            if (dp_stat.op == OP_PUSH_FRONT || dp_stat.op == OP_PUSH_BACK) begin
               dp_cmd.stg_last = 1'b1;
               if (dp_stat.full) begin
                  dp_cmd.stg_src    = STG_ERR;
                  dp_cmd.stg_status = ST_FULL;
               end else begin
                  dp_cmd.push    = 1'b1;
                  dp_cmd.stg_src = STG_CMD;
               end
               state_in = S_MUL;
            end else if (dp_stat.empty) begin
               dp_cmd.stg_src    = STG_ERR;
               dp_cmd.stg_status = ST_EMPTY;
               dp_cmd.stg_last   = 1'b1;
               state_in          = S_MUL;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            case (dp_stat.op) inside
               OP_POP_FRONT, OP_POP_BACK: begin
                  dp_cmd.pop      = 1'b1;
                  dp_cmd.stg_src  = STG_RAM;
                  dp_cmd.stg_last = 1'b1;
                  state_in        = S_MUL;
               end
               OP_SEARCH: begin
                  if (dp_stat.match) begin
                     dp_cmd.stg_src  = STG_RAM;
                     dp_cmd.stg_last = 1'b1;
                     state_in        = S_MUL;
                  end else if (dp_stat.walk_end) begin
                     dp_cmd.stg_src    = STG_ERR;
                     dp_cmd.stg_status = ST_NOT_FOUND;
                     dp_cmd.stg_last   = 1'b1;
                     state_in          = S_MUL;
                  end else begin
                     dp_cmd.walk_inc = 1'b1;
                     state_in        = S_FETCH;
                  end
               end
               OP_DUMP: begin
                  dp_cmd.stg_src  = STG_RAM;
                  dp_cmd.stg_last = dp_stat.walk_end;
                  state_in        = S_MUL;
               end
               default: begin
                  dp_cmd.stg_src  = STG_RAM;
                  dp_cmd.stg_last = 1'b1;
                  state_in        = S_MUL;
               end
            endcase
         end
         S_MUL: begin
            dp_cmd.ld_prod = 1'b1;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (dp_stat.out_free) begin
               dp_cmd.ld_out = 1'b1;
               if (dp_stat.stg_last) begin
                  state_in = S_IDLE;
               end else begin
                  dp_cmd.walk_inc = 1'b1;
                  state_in        = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

// ===== design/rdws_datapath.sv =====
// Datapath of the record deque: ring pointers, entry RAM, bill multiplier, output register.
`timescale 1ns / 1ps
module rdws_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [rdws_pkg::RATE_W-1:0]    csr_wr_data,
   input  logic [rdws_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [rdws_pkg::ID_W-1:0]      req_customer_id,
   input  logic [rdws_pkg::GROUP_W-1:0]   req_tariff_group,
   input  logic [rdws_pkg::USAGE_W-1:0]   req_usage_amount,
   input  logic                           req_dump_reverse,
   input  rdws_pkg::dp_cmd_type           dp_cmd,
   output rdws_pkg::dp_stat_type          dp_stat,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rdws_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rdws_pkg::POS_W-1:0]     rsp_position,
   output logic [rdws_pkg::ID_W-1:0]      rsp_record_id,
   output logic [rdws_pkg::GROUP_W-1:0]   rsp_record_group,
   output logic [rdws_pkg::USAGE_W-1:0]   rsp_record_usage,
   output logic [rdws_pkg::BILL_W-1:0]    rsp_bill,
   output logic                           rsp_last
);
   import rdws_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [IW-1:0]      front_ff, front_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      walk_ff, walk_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic               out_valid_ff, out_valid_in;

   opcode_type         op_ff, op_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [GROUP_W-1:0] group_ff, group_in;
   logic [USAGE_W-1:0] usage_ff, usage_in;
   logic               rev_ff, rev_in;

   record_type         stg_rec_ff, stg_rec_in;
   logic [POS_W-1:0]   stg_pos_ff, stg_pos_in;
   status_type         stg_status_ff, stg_status_in;
   logic               stg_last_ff, stg_last_in;
   logic [BILL_W-1:0]  prod_ff, prod_in;

   record_type         out_rec_ff, out_rec_in;
   logic [POS_W-1:0]   out_pos_ff, out_pos_in;
   status_type         out_status_ff, out_status_in;
   logic [BILL_W-1:0]  out_bill_ff, out_bill_in;
   logic               out_last_ff, out_last_in;

   logic               back_single;
   logic               back_sel;
   logic [CW-1:0]      walk_off;
   logic [CW-1:0]      walk_next;
   logic [IW-1:0]      rd_slot;
   logic [IW-1:0]      front_dec;
   logic [IW-1:0]      front_inc;
   logic [IW-1:0]      push_slot;
   record_type         push_rec;
   record_type         ram_rd_data;

   function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   assign back_single = (op_ff == OP_POP_BACK) || (op_ff == OP_PEEK_BACK);
   assign back_sel    = back_single || (op_ff == OP_DUMP && rev_ff);
   assign walk_off    = back_sel ? (count_ff - CW'(1) - walk_ff) : walk_ff;
   assign walk_next   = walk_ff + CW'(1);
   assign rd_slot     = ring_add(front_ff, walk_off);
   assign front_dec   = (front_ff == '0) ? IW'(DEPTH - 1) : front_ff - IW'(1);
   assign front_inc   = ring_add(front_ff, CW'(1));
   assign push_slot   = (op_ff == OP_PUSH_FRONT) ? front_dec : ring_add(front_ff, count_ff);

   always_comb begin
      push_rec.id    = id_ff;
      push_rec.group = group_ff;
      push_rec.usage = usage_ff;
   end

   rdws_ram #(
      .WIDTH ($bits(record_type)),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (dp_cmd.push),
      .wr_addr (push_slot),
      .wr_data (push_rec),
      .rd_addr (rd_slot),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      rate_in       = csr_wr_en ? csr_wr_data : rate_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      group_in      = group_ff;
      usage_in      = usage_ff;
      rev_in        = rev_ff;
      stg_rec_in    = stg_rec_ff;
      stg_pos_in    = stg_pos_ff;
      stg_status_in = stg_status_ff;
      stg_last_in   = stg_last_ff;
      prod_in       = prod_ff;
      out_rec_in    = out_rec_ff;
      out_pos_in    = out_pos_ff;
      out_status_in = out_status_ff;
      out_bill_in   = out_bill_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;

      if (dp_cmd.take_cmd) begin
         op_in    = opcode_type'(req_opcode);
         id_in    = req_customer_id;
         group_in = req_tariff_group;
         usage_in = req_usage_amount;
         rev_in   = req_dump_reverse;
         walk_in  = '0;
      end
      if (dp_cmd.walk_inc) begin
         walk_in = walk_next;
      end
      if (dp_cmd.push) begin
         count_in = count_ff + CW'(1);
         if (op_ff == OP_PUSH_FRONT) begin
            front_in = front_dec;
         end
      end
      if (dp_cmd.pop) begin
         count_in = count_ff - CW'(1);
         if (op_ff == OP_POP_FRONT) begin
            front_in = front_inc;
         end
      end

      case (dp_cmd.stg_src)
         STG_CMD: begin
            stg_rec_in = push_rec;
            stg_pos_in = (op_ff == OP_PUSH_FRONT) ? POS_W'(1) : POS_W'(count_ff) + POS_W'(1);
         end
         STG_RAM: begin
            stg_rec_in = ram_rd_data;
            stg_pos_in = back_single ? POS_W'(count_ff) : POS_W'(walk_next);
         end
         STG_ERR: begin
            stg_rec_in = '0;
            stg_pos_in = '0;
         end
         default: begin
         end
      endcase
      if (dp_cmd.stg_src != STG_HOLD) begin
         stg_status_in = dp_cmd.stg_status;
         stg_last_in   = dp_cmd.stg_last;
      end

      if (dp_cmd.ld_prod) begin
         prod_in = BILL_W'(stg_rec_ff.usage) * BILL_W'(rate_ff);
      end

      if (dp_cmd.ld_out) begin
         out_rec_in    = stg_rec_ff;
         out_pos_in    = stg_pos_ff;
         out_status_in = stg_status_ff;
         out_bill_in   = prod_ff;
         out_last_in   = stg_last_ff;
         out_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         walk_ff      <= '0;
         rate_ff      <= RATE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         rate_ff      <= rate_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      group_ff      <= group_in;
      usage_ff      <= usage_in;
      rev_ff        <= rev_in;
      stg_rec_ff    <= stg_rec_in;
      stg_pos_ff    <= stg_pos_in;
      stg_status_ff <= stg_status_in;
      stg_last_ff   <= stg_last_in;
      prod_ff       <= prod_in;
      out_rec_ff    <= out_rec_in;
      out_pos_ff    <= out_pos_in;
      out_status_ff <= out_status_in;
      out_bill_ff   <= out_bill_in;
      out_last_ff   <= out_last_in;
   end

   always_comb begin
      dp_stat.op       = op_ff;
      dp_stat.full     = (count_ff == CW'(DEPTH));
      dp_stat.empty    = (count_ff == '0);
      dp_stat.match    = (ram_rd_data.id == id_ff);
      dp_stat.walk_end = (walk_next == count_ff);
      dp_stat.out_free = !out_valid_ff || rsp_ready;
      dp_stat.stg_last = stg_last_ff;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_position     = out_pos_ff;
   assign rsp_record_id    = out_rec_ff.id;
   assign rsp_record_group = out_rec_ff.group;
   assign rsp_record_usage = out_rec_ff.usage;
   assign rsp_bill         = out_bill_ff;
   assign rsp_last         = out_last_ff;
endmodule

// ===== design/record_deque_with_search.sv =====
// Top level of the record deque with search, dump and billing.
//
// Usage: commands enter on req_chan (valid/ready); each command produces one or
// more result items on rsp_chan, the final one flagged by last. Dump produces one
// item per stored record (one empty-status item on an empty deque); every other command produces exactly one item.
// csr_wr_en/csr_wr_data set the rate per unit that multiplies usage into bill.
// Path from acceptance to result valid: push or error results go through DECODE, MUL and EMIT;
// pop/peek go through DECODE, FETCH, LOAD, MUL and EMIT; search repeats FETCH and LOAD per entry
// until a hit or a miss; dump repeats FETCH, LOAD, MUL and EMIT for each record.
// Each record costs an entry RAM read (registered) and a registered multiply
// before it lands in the output register.
// One command is in flight at a time; req_chan.ready is high only between
// commands, including while the last result still sits in the output register.
// Reset empties the deque (front and count cleared), sets the rate to 500 and
// drops any pending result. Entry RAM contents are not cleared.
// A stalled receiver holds the output register; the walk pauses until it drains.
`timescale 1ns / 1ps
`include "record_deque_with_search_assert.svh"
module record_deque_with_search #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [rdws_pkg::RATE_W-1:0] csr_wr_data,
   rdws_req_if.sink                    req_chan,
   rdws_rsp_if.source                  rsp_chan
);
   import rdws_pkg::*;

   dp_cmd_type  ctl_cmd;
   dp_stat_type ctl_stat;

   rdws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .dp_stat   (ctl_stat),
      .dp_cmd    (ctl_cmd)
   );

   rdws_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_opcode       (req_chan.opcode),
      .req_customer_id  (req_chan.customer_id),
      .req_tariff_group (req_chan.tariff_group),
      .req_usage_amount (req_chan.usage_amount),
      .req_dump_reverse (req_chan.dump_reverse),
      .dp_cmd           (ctl_cmd),
      .dp_stat          (ctl_stat),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_position     (rsp_chan.position),
      .rsp_record_id    (rsp_chan.record_id),
      .rsp_record_group (rsp_chan.record_group),
      .rsp_record_usage (rsp_chan.record_usage),
      .rsp_bill         (rsp_chan.bill),
      .rsp_last         (rsp_chan.last)
   );

   `RDWS_ASSERT_NEXT(a_one_cmd_in_flight, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `RDWS_ASSERT_NOW(a_no_result_overwrite, clock, reset, ctl_cmd.ld_out, ctl_stat.out_free)
   `RDWS_ASSERT_NOW(a_push_not_full, clock, reset, ctl_cmd.push, !ctl_stat.full)
   `RDWS_ASSERT_NOW(a_pop_not_empty, clock, reset, ctl_cmd.pop, !ctl_stat.empty)
endmodule
